>>> rtl/rdmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdmc_pkg
// Shared types, codes and register layout of the rover drive mode controller.
// ----------------------------------------------------------------------------
package rdmc_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 32;

  localparam logic [CfgIndexWidth-1:0] REG_BUTTON_TIMEOUT = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MOVE_MODE      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_SPEED_GO       = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_STEER_TURN     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_PWM_MID        = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_PWM_DEV        = 3'd5;

  localparam logic [31:0] BUTTON_TIMEOUT_RESET = 32'd1000;
  localparam logic [7:0]  MOVE_MODE_RESET      = 8'd0;
  localparam logic [14:0] SPEED_GO_RESET       = 15'd0;
  localparam logic [14:0] STEER_TURN_RESET     = 15'd0;
  localparam logic [11:0] PWM_MID_RESET        = 12'd1500;
  localparam logic [10:0] PWM_DEV_RESET        = 11'd500;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_BUTTON = 2'd1;
  localparam logic [1:0] ACT_AUTO   = 2'd2;

  localparam logic [2:0] BTN_NONE  = 3'd0;
  localparam logic [2:0] BTN_FWD   = 3'd1;
  localparam logic [2:0] BTN_LEFT  = 3'd2;
  localparam logic [2:0] BTN_RIGHT = 3'd3;
  localparam logic [2:0] BTN_BACK  = 3'd4;
  localparam logic [2:0] BTN_STOP  = 3'd5;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_MANUAL  = 2'd1,
    MODE_AUTO    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] button;
    logic       obstacle;
    logic       fence_breach;
    logic [7:0] ap_mode;
    logic       ap_armed;
  } item_t;

  typedef struct packed {
    logic [12:0] steer_pwm;
    logic [12:0] throttle_pwm;
    logic [1:0]  drive_mode;
    logic        request_mode_change;
    logic        request_arm;
    logic        accepted;
  } result_t;

  typedef struct packed {
    logic [31:0] button_timeout;
    logic [7:0]  move_mode;
    logic [14:0] speed_go;
    logic [14:0] steer_turn;
    logic [11:0] pwm_mid;
    logic [10:0] pwm_dev;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic               req_mode;
    logic               req_arm;
    logic               accepted;
    logic signed [15:0] steer;
    logic signed [15:0] speed;
  } ctrl_out_t;

endpackage
`default_nettype wire

>>> rtl/rover_drive_mode_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rover_drive_mode_controller_core
// Rover drive mode controller: one item per cycle while results are taken. An
// accepted beat lands in the input register; its result beat is presented from
// the result register. The mode update, the steer/speed choice and the two
// multiply-shift-add-clamp PWM maps run in one pass between those registers.
// While a result beat waits to be taken, the input register still takes one
// more beat; after that item_ready stays low until the result is taken.
// Configuration writes take effect at once and are to be made while idle.
// ----------------------------------------------------------------------------
module rover_drive_mode_controller_core
  import rdmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [CfgIndexWidth-1:0] wr_index,
  input  wire logic [CfgDataWidth-1:0]  wr_data,
  input  wire logic                     item_valid,
  output logic                          item_ready,
  input  wire item_t                    item,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output result_t                       result
);

  cfg_t      cfg;
  item_t     item_q;
  logic      item_valid_q;
  logic      advance;
  ctrl_out_t ctrl;
  logic [12:0] steer_pwm;
  logic [12:0] throttle_pwm;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_timeout <= BUTTON_TIMEOUT_RESET;
      cfg.move_mode      <= MOVE_MODE_RESET;
      cfg.speed_go       <= SPEED_GO_RESET;
      cfg.steer_turn     <= STEER_TURN_RESET;
      cfg.pwm_mid        <= PWM_MID_RESET;
      cfg.pwm_dev        <= PWM_DEV_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_BUTTON_TIMEOUT: cfg.button_timeout <= wr_data[31:0];
        REG_MOVE_MODE:      cfg.move_mode      <= wr_data[7:0];
        REG_SPEED_GO:       cfg.speed_go       <= wr_data[14:0];
        REG_STEER_TURN:     cfg.steer_turn     <= wr_data[14:0];
        REG_PWM_MID:        cfg.pwm_mid        <= wr_data[11:0];
        REG_PWM_DEV:        cfg.pwm_dev        <= wr_data[10:0];
        default: ;
      endcase
    end
  end

  assign advance    = item_valid_q && (!result_valid || result_ready);
  assign item_ready = !item_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid_q <= 1'b0;
    end else if (item_ready) begin
      item_valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  rdmc_mode_ctrl u_mode_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item_q),
    .cfg  (cfg),
    .ctrl (ctrl)
  );

  rdmc_pwm_map u_steer_map (
    .value (ctrl.steer),
    .mid   (cfg.pwm_mid),
    .dev   (cfg.pwm_dev),
    .pwm   (steer_pwm)
  );

  rdmc_pwm_map u_throttle_map (
    .value (ctrl.speed),
    .mid   (cfg.pwm_mid),
    .dev   (cfg.pwm_dev),
    .pwm   (throttle_pwm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.steer_pwm           <= steer_pwm;
      result.throttle_pwm        <= throttle_pwm;
      result.drive_mode          <= ctrl.mode;
      result.request_mode_change <= ctrl.req_mode;
      result.request_arm         <= ctrl.req_arm;
      result.accepted            <= ctrl.accepted;
    end
  end

  a_requests_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.request_mode_change && result.request_arm))
    else $error("mode change and arm requested together");

  a_rejected_no_request: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.accepted)
      |-> (!result.request_mode_change && !result.request_arm))
    else $error("request raised on a rejected beat");

  a_pwm_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.steer_pwm <= ({1'b0, cfg.pwm_mid} + {2'b00, cfg.pwm_dev})
      && result.throttle_pwm <= ({1'b0, cfg.pwm_mid} + {2'b00, cfg.pwm_dev})))
    else $error("PWM above upper clamp");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid_q && !advance) |=> (item_valid_q && $stable(item_q)))
    else $error("stalled input beat lost or changed");

endmodule
`default_nettype wire

>>> rtl/rdmc_pwm_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdmc_pwm_map
// Maps a signed Q1.14 value to PWM: floor(v * dev / 2^14) + mid, clamped to
// [max(mid - dev, 0), mid + dev].
// ----------------------------------------------------------------------------
module rdmc_pwm_map
  import rdmc_pkg::*;
(
  input  wire logic signed [15:0] value,
  input  wire logic        [11:0] mid,
  input  wire logic        [10:0] dev,
  output logic             [12:0] pwm
);

  logic signed [27:0] prod;
  logic signed [13:0] quot;
  logic signed [14:0] sum;
  logic signed [13:0] diff;
  logic        [12:0] lo;
  logic        [12:0] hi;

  always_comb begin
    prod = value * $signed({1'b0, dev});
    quot = prod[27:14];
    sum  = $signed({quot[13], quot}) + $signed({3'b000, mid});
    diff = $signed({2'b00, mid}) - $signed({3'b000, dev});
    lo   = diff[13] ? 13'd0 : diff[12:0];
    hi   = {1'b0, mid} + {2'b00, dev};
    if (sum < $signed({2'b00, lo})) begin
      pwm = lo;
    end else if (sum > $signed({2'b00, hi})) begin
      pwm = hi;
    end else begin
      pwm = sum[12:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/rdmc_mode_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdmc_mode_ctrl
// Drive mode state, held button, tick counter and steer/speed selection.
// Updates state on each step and presents the values of the stepped item.
// ----------------------------------------------------------------------------
module rdmc_mode_ctrl
  import rdmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire item_t     item,
  input  wire cfg_t      cfg,
  output ctrl_out_t      ctrl
);

  mode_t              mode_reg;
  logic [2:0]         held_button;
  logic [31:0]        since_button;
  logic signed [15:0] steer_value;
  logic signed [15:0] speed_value;

  mode_t              mode_reg_next;
  logic [2:0]         held_button_next;
  logic [31:0]        since_button_next;
  logic signed [15:0] steer_value_next;
  logic signed [15:0] speed_value_next;
  logic signed [15:0] go_val;
  logic signed [15:0] turn_val;

  always_comb begin
    mode_reg_next     = mode_reg;
    held_button_next  = held_button;
    since_button_next = since_button;
    steer_value_next  = steer_value;
    speed_value_next  = speed_value;
    go_val            = $signed({1'b0, cfg.speed_go});
    turn_val          = $signed({1'b0, cfg.steer_turn});
    ctrl.req_mode     = 1'b0;
    ctrl.req_arm      = 1'b0;
    ctrl.accepted     = 1'b0;
    case (item.action)
      ACT_TICK: begin
        ctrl.accepted = 1'b1;
        if (since_button != '1) begin
          since_button_next = since_button + 32'd1;
        end
        if (since_button_next > cfg.button_timeout) begin
          held_button_next = BTN_NONE;
        end
        case (held_button_next)
          BTN_NONE: begin
            if (mode_reg == MODE_MANUAL) begin
              mode_reg_next = MODE_STANDBY;
            end
          end
          BTN_STOP: mode_reg_next = MODE_STANDBY;
          default:  mode_reg_next = MODE_MANUAL;
        endcase
        if (mode_reg_next == MODE_STANDBY) begin
          steer_value_next = '0;
          speed_value_next = '0;
        end else begin
          if (item.ap_mode == cfg.move_mode) begin
            ctrl.req_arm = !item.ap_armed;
          end else begin
            ctrl.req_mode = 1'b1;
          end
          if (mode_reg_next == MODE_MANUAL) begin
            case (held_button_next)
              BTN_FWD: begin
                steer_value_next = '0;
                speed_value_next = go_val;
              end
              BTN_BACK: begin
                steer_value_next = '0;
                speed_value_next = -go_val;
              end
              BTN_LEFT: begin
                steer_value_next = -turn_val;
                speed_value_next = '0;
              end
              BTN_RIGHT: begin
                steer_value_next = turn_val;
                speed_value_next = '0;
              end
              default: ;
            endcase
          end else if (!item.obstacle && !item.fence_breach) begin
            steer_value_next = '0;
            speed_value_next = go_val;
          end else begin
            steer_value_next = turn_val;
            speed_value_next = '0;
          end
        end
      end
      ACT_BUTTON: begin
        if (item.button inside {[BTN_FWD:BTN_STOP]}) begin
          held_button_next  = item.button;
          since_button_next = '0;
          ctrl.accepted     = 1'b1;
        end
      end
      ACT_AUTO: begin
        mode_reg_next = MODE_AUTO;
        ctrl.accepted = 1'b1;
      end
      default: ;
    endcase
    ctrl.mode  = mode_reg_next;
    ctrl.steer = steer_value_next;
    ctrl.speed = speed_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_STANDBY;
      held_button  <= BTN_NONE;
      since_button <= '1;
      steer_value  <= '0;
      speed_value  <= '0;
    end else if (step) begin
      mode_reg     <= mode_reg_next;
      held_button  <= held_button_next;
      since_button <= since_button_next;
      steer_value  <= steer_value_next;
      speed_value  <= speed_value_next;
    end
  end

  a_manual_has_button: assert property (@(posedge clk) disable iff (rst)
    (mode_reg == MODE_MANUAL) |-> (held_button != BTN_NONE))
    else $error("manual mode without a held button");

  a_standby_zero: assert property (@(posedge clk) disable iff (rst)
    (step && item.action == ACT_TICK && ctrl.mode == MODE_STANDBY)
      |=> (steer_value == 16'sd0 && speed_value == 16'sd0))
    else $error("standby tick left nonzero steer or speed");

  a_button_clears_count: assert property (@(posedge clk) disable iff (rst)
    (step && item.action == ACT_BUTTON && ctrl.accepted) |=> (since_button == 32'd0))
    else $error("accepted button did not clear the tick count");

endmodule
`default_nettype wire
